[rtl/jacobi_stencil_3d_sweep_core_defines.svh]
// Assertion macros used by the checker file of the stencil sweep core.
`ifndef JACOBI_STENCIL_3D_SWEEP_CORE_DEFINES_SVH
`define JACOBI_STENCIL_3D_SWEEP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define JSW_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define JSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/jsw_pkg.sv]
// Shared types, constants and size helpers of the stencil sweep core.
package jsw_pkg;

  // Default build sizes.
  localparam int DEF_MAX_SIZE   = 128;
  localparam int DEF_VALUE_BITS = 17;

  // Configuration register.
  localparam int GRID_BITS  = 8;
  localparam int GRID_RESET = 128;
  localparam int MIN_SIZE   = 3;

  // Fixed point: 1.0 is 65536, one sixth is 10923.
  localparam int RESULT_BITS = 17;
  localparam int FRAC_BITS   = 16;
  localparam int ONE_FIXED   = 65536;
  localparam int ROUND_HALF  = 32768;
  localparam int SIXTH_FIXED = 10923;
  localparam int SIXTH_BITS  = 14;

  // Depth of the queue between front and back.
  localparam int FIFO_DEPTH = 4;

  // Per-word classification handed from the front to the back.
  typedef struct packed {
    logic emit;
    logic last;
  } jsw_flags_t;

  // Edge length the block works with for a given register value.
  function automatic int eff_size(int grid, int max_size);
    int n;
    n = grid;
    if (n < MIN_SIZE) n = MIN_SIZE;
    if (n > max_size) n = max_size;
    return n;
  endfunction

  // Longest delay segment: one plane less one row and one voxel.
  function automatic int far_depth(int max_size);
    return max_size * max_size - max_size - 1;
  endfunction

  // Short delay segment: one row less two voxels.
  function automatic int row_depth(int max_size);
    return max_size - 2;
  endfunction

endpackage

[rtl/jsw_delay.sv]
// Variable-length delay line built on a single-port-per-side memory.
module jsw_delay #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 17,
  localparam int LenW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic             step_i,
  input  logic [LenW-1:0]  len_i,
  input  logic [WIDTH-1:0] din_i,
  output logic [WIDTH-1:0] dout_o
);

  localparam int MemDepth = (DEPTH > 1) ? DEPTH : 2;
  localparam int AddrW    = $clog2(MemDepth);

  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [WIDTH-1:0] mem_q [MemDepth];
  logic [WIDTH-1:0] dout_q;

  // The pointer runs over the first len_i entries of the memory.
  always_comb begin
    ptr_d = ptr_q;
    if (step_i) begin
      if (LenW'(ptr_q) == len_i - LenW'(1)) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (restart_i) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // Read the oldest word before it is overwritten by the newest one.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      dout_q         <= mem_q[ptr_q];
      mem_q[ptr_q]   <= din_i;
    end
  end

  assign dout_o = dout_q;

endmodule

[rtl/jsw_fifo.sv]
// Short register queue that decouples the front from the back.
module jsw_fifo #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int AddrW  = $clog2(DEPTH);
  localparam int CountW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem_q [DEPTH];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;

  assign full_o  = (count_q == CountW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CountW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/jsw_front.sv]
// Front end: grid register, raster position counters and voxel classification.
module jsw_front #(
  parameter int MAX_SIZE   = 128,
  parameter int VALUE_BITS = 17,
  localparam int FarLenW   = $clog2(jsw_pkg::far_depth(MAX_SIZE) + 1),
  localparam int RowLenW   = $clog2(jsw_pkg::row_depth(MAX_SIZE) + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jsw_pkg::GRID_BITS-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic [VALUE_BITS-1:0]          cell_value_i,
  output logic                           in_stall_o,
  input  logic                           fifo_full_i,
  output logic                           push_o,
  output logic [VALUE_BITS-1:0]          push_value_o,
  output jsw_pkg::jsw_flags_t            push_flags_o,
  output logic                           restart_o,
  output logic [FarLenW-1:0]             far_len_o,
  output logic [RowLenW-1:0]             row_len_o
);

  import jsw_pkg::*;

  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int PW    = $clog2(MAX_SIZE);
  localparam int CmpW  = (NW > GRID_BITS) ? NW : GRID_BITS;
  localparam int SqW   = 2 * NW;
  localparam int RstN  = eff_size(GRID_RESET, MAX_SIZE);

  logic [CmpW-1:0]    grid_ext, size_cmp;
  logic [NW-1:0]      size_n;
  logic [SqW-1:0]     size_sq;
  logic [PW-1:0]      nm1_q, nm2_q;
  logic [FarLenW-1:0] far_len_q;
  logic [RowLenW-1:0] row_len_q;
  logic [PW-1:0]      col_q, row_q, plane_q;
  logic [PW-1:0]      col_d, row_d, plane_d;
  logic               accept;
  logic               interior;

  // Clamp the written edge length into the supported range.
  always_comb begin
    grid_ext = CmpW'(cfg_wdata_i);
    priority if (grid_ext < CmpW'(MIN_SIZE)) begin
      size_cmp = CmpW'(MIN_SIZE);
    end else if (grid_ext > CmpW'(MAX_SIZE)) begin
      size_cmp = CmpW'(MAX_SIZE);
    end else begin
      size_cmp = grid_ext;
    end
    size_n  = NW'(size_cmp);
    size_sq = SqW'(size_n) * SqW'(size_n);
  end

  // Geometry registers, loaded on every configuration write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm1_q     <= PW'(RstN - 1);
      nm2_q     <= PW'(RstN - 2);
      far_len_q <= FarLenW'(RstN * RstN - RstN - 1);
      row_len_q <= RowLenW'(RstN - 2);
    end else if (cfg_we_i) begin
      nm1_q     <= PW'(size_n - NW'(1));
      nm2_q     <= PW'(size_n - NW'(2));
      far_len_q <= FarLenW'(size_sq - SqW'(size_n) - SqW'(1));
      row_len_q <= RowLenW'(size_n - NW'(2));
    end
  end

  assign accept     = in_valid_i && !fifo_full_i;
  assign in_stall_o = fifo_full_i;

  // Raster position of the next voxel: column, then row, then plane.
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    plane_d = plane_q;
    if (accept) begin
      if (col_q == nm1_q) begin
        col_d = '0;
        if (row_q == nm1_q) begin
          row_d   = '0;
          plane_d = (plane_q == nm1_q) ? '0 : plane_q + PW'(1);
        end else begin
          row_d = row_q + PW'(1);
        end
      end else begin
        col_d = col_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      plane_q <= '0;
    end else if (cfg_we_i) begin
      col_q   <= '0;
      row_q   <= '0;
      plane_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      plane_q <= plane_d;
    end
  end

  // The incoming voxel completes the stencil of the voxel one plane above it.
  assign interior = (plane_q >= PW'(2)) &&
                    (row_q >= PW'(1)) && (row_q <= nm2_q) &&
                    (col_q >= PW'(1)) && (col_q <= nm2_q);

  assign push_o            = accept;
  assign push_value_o      = cell_value_i;
  assign push_flags_o.emit = interior;
  assign push_flags_o.last = interior && (plane_q == nm1_q) &&
                             (row_q == nm2_q) && (col_q == nm2_q);

  assign restart_o = cfg_we_i;
  assign far_len_o = far_len_q;
  assign row_len_o = row_len_q;

endmodule

[rtl/jsw_back.sv]
// Back end: neighbour delay chain, sum, scale by one sixth, saturate, output register.
module jsw_back #(
  parameter int MAX_SIZE   = 128,
  parameter int VALUE_BITS = 17,
  localparam int FarLenW   = $clog2(jsw_pkg::far_depth(MAX_SIZE) + 1),
  localparam int RowLenW   = $clog2(jsw_pkg::row_depth(MAX_SIZE) + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            restart_i,
  input  logic [FarLenW-1:0]              far_len_i,
  input  logic [RowLenW-1:0]              row_len_i,
  input  logic                            fifo_empty_i,
  input  logic [VALUE_BITS-1:0]           fifo_value_i,
  input  jsw_pkg::jsw_flags_t             fifo_flags_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [jsw_pkg::RESULT_BITS-1:0] new_value_o,
  output logic                            last_of_sweep_o
);

  import jsw_pkg::*;

  localparam int FarDepth = far_depth(MAX_SIZE);
  localparam int RowDepth = row_depth(MAX_SIZE);
  localparam int PartW    = VALUE_BITS + 2;
  localparam int SumW     = VALUE_BITS + 3;
  localparam int ProdW    = SumW + SIXTH_BITS;
  localparam int RndW     = ProdW + 1 - FRAC_BITS;
  localparam int SatW     = (RndW > RESULT_BITS) ? RndW : RESULT_BITS;

  logic                   adv, step;
  logic [VALUE_BITS-1:0]  tap_a, tap_b, tap_d, tap_e;
  logic [VALUE_BITS-1:0]  hold_q, tap_c_q;
  logic                   s1_valid_q, s1_last_q;
  logic [PartW-1:0]       part0_q, part1_q;
  logic                   s2_valid_q, s2_last_q;
  logic [SumW-1:0]        sum_q;
  logic                   s3_valid_q, s3_last_q;
  logic [ProdW-1:0]       prod_q;
  logic [ProdW:0]         rnd_full;
  logic [SatW-1:0]        rnd;
  logic [RESULT_BITS-1:0] result;
  logic                   out_valid_q, out_last_q;
  logic [RESULT_BITS-1:0] out_value_q;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv   = !out_valid_q || !out_stall_i;
  assign step  = adv && !fifo_empty_i;
  assign pop_o = step;

  // Delay chain: taps lie one plane, one row and one voxel on either side of the centre.
  jsw_delay #(.DEPTH(FarDepth), .WIDTH(VALUE_BITS)) u_delay_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart_i),
    .step_i    (step),
    .len_i     (far_len_i),
    .din_i     (fifo_value_i),
    .dout_o    (tap_a)
  );

  jsw_delay #(.DEPTH(RowDepth), .WIDTH(VALUE_BITS)) u_delay_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart_i),
    .step_i    (step),
    .len_i     (row_len_i),
    .din_i     (tap_a),
    .dout_o    (tap_b)
  );

  // Two-word gap between the voxels left and right of the centre.
  always_ff @(posedge clk_i) begin
    if (step) begin
      hold_q  <= tap_b;
      tap_c_q <= hold_q;
    end
  end

  jsw_delay #(.DEPTH(RowDepth), .WIDTH(VALUE_BITS)) u_delay_d (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart_i),
    .step_i    (step),
    .len_i     (row_len_i),
    .din_i     (tap_c_q),
    .dout_o    (tap_d)
  );

  jsw_delay #(.DEPTH(FarDepth), .WIDTH(VALUE_BITS)) u_delay_e (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart_i),
    .step_i    (step),
    .len_i     (far_len_i),
    .din_i     (tap_d),
    .dout_o    (tap_e)
  );

  // Rounding and saturation at 1.0.
  always_comb begin
    rnd_full = {1'b0, prod_q} + (ProdW + 1)'(ROUND_HALF);
    rnd      = SatW'(rnd_full[ProdW:FRAC_BITS]);
    if (rnd > SatW'(ONE_FIXED)) begin
      result = RESULT_BITS'(ONE_FIXED);
    end else begin
      result = rnd[RESULT_BITS-1:0];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= step && fifo_flags_i.emit;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // Stage payload: partial sums, full sum, product, rounded result.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q   <= fifo_flags_i.last;
      part0_q     <= PartW'(fifo_value_i) + PartW'(tap_a) + PartW'(tap_b);
      part1_q     <= PartW'(tap_c_q) + PartW'(tap_d) + PartW'(tap_e);
      s2_last_q   <= s1_last_q;
      sum_q       <= SumW'(part0_q) + SumW'(part1_q);
      s3_last_q   <= s2_last_q;
      prod_q      <= ProdW'(sum_q) * ProdW'(SIXTH_FIXED);
      out_last_q  <= s3_last_q;
      out_value_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_value_o     = out_value_q;
  assign last_of_sweep_o = out_last_q;

endmodule

[rtl/jacobi_stencil_3d_sweep_core.sv]
// Top level of the streaming 3D seven-point Jacobi sweep core.
//
// Input words carry one voxel each in raster order (plane, row, column) and
// are taken at a clock edge with in_valid_i high and in_stall_o low. Output
// words carry the new value of each interior voxel, in raster order of the
// interior, with last_of_sweep_o set on the final one; boundary voxels give
// no output word. The edge length is written through cfg_we_i/cfg_wdata_i
// while the core is idle; each write restarts the sweep at voxel (0,0,0).
// Throughput is one voxel per clock while the output is not stalled. The result
// for an interior voxel is offered after the voxel one plane above it is taken:
// partial sums on leaving the input queue, then full sum, multiply, output register.
// The neighbour window is four delay memories of up to one plane each plus
// two registers; each memory does one read and one write per voxel.
// A stall on the output holds the whole back pipeline; the four-word queue
// keeps taking input until it fills, then in_stall_o rises.
// Reset sets the edge length to 128 and the position to voxel (0,0,0). There
// is no clearing pass: the window only supplies taps written in this sweep.
module jacobi_stencil_3d_sweep_core #(
  parameter int MAX_SIZE   = jsw_pkg::DEF_MAX_SIZE,
  parameter int VALUE_BITS = jsw_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [jsw_pkg::GRID_BITS-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [VALUE_BITS-1:0]           cell_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [jsw_pkg::RESULT_BITS-1:0] new_value_o,
  output logic                            last_of_sweep_o
);

  import jsw_pkg::*;

  localparam int FarLenW = $clog2(far_depth(MAX_SIZE) + 1);
  localparam int RowLenW = $clog2(row_depth(MAX_SIZE) + 1);
  localparam int EntryW  = VALUE_BITS + $bits(jsw_flags_t);

  logic                  push, pop, fifo_full, fifo_empty, restart;
  logic [VALUE_BITS-1:0] push_value;
  jsw_flags_t            push_flags, pop_flags;
  logic [EntryW-1:0]     fifo_wdata, fifo_rdata;
  logic [FarLenW-1:0]    far_len;
  logic [RowLenW-1:0]    row_len;

  // Front: configuration, position tracking, classification.
  jsw_front #(.MAX_SIZE(MAX_SIZE), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .cell_value_i (cell_value_i),
    .in_stall_o   (in_stall_o),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .push_value_o (push_value),
    .push_flags_o (push_flags),
    .restart_o    (restart),
    .far_len_o    (far_len),
    .row_len_o    (row_len)
  );

  // Queue words carry the voxel value and its classification.
  assign fifo_wdata = {push_flags, push_value};

  jsw_fifo #(.WIDTH(EntryW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (fifo_wdata),
    .pop_i   (pop),
    .rdata_o (fifo_rdata),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  assign pop_flags = jsw_flags_t'(fifo_rdata[EntryW-1:VALUE_BITS]);

  // Back: neighbour window and arithmetic.
  jsw_back #(.MAX_SIZE(MAX_SIZE), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .restart_i       (restart),
    .far_len_i       (far_len),
    .row_len_i       (row_len),
    .fifo_empty_i    (fifo_empty),
    .fifo_value_i    (fifo_rdata[VALUE_BITS-1:0]),
    .fifo_flags_i    (pop_flags),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .new_value_o     (new_value_o),
    .last_of_sweep_o (last_of_sweep_o)
  );

endmodule

[rtl/jsw_checker.sv]
// Port-level checks of the stencil sweep core and their binding to the top level.
`include "jacobi_stencil_3d_sweep_core_defines.svh"

module jsw_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [jsw_pkg::RESULT_BITS-1:0] new_value_o,
  input logic                            last_of_sweep_o
);

  import jsw_pkg::*;

  // A stalled output word stays offered and unchanged.
  `JSW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output word dropped while stalled")
  `JSW_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(new_value_o) && $stable(last_of_sweep_o), "output word changed while stalled")

  // An empty output register lets the back drain the queue, so input opens up.
  `JSW_ASSERT_NEXT(a_in_free, !out_valid_o, !in_stall_o, "input still stalled after an idle output")

  // Results never exceed 1.0.
  `JSW_ASSERT(a_sat, out_valid_o, new_value_o <= RESULT_BITS'(ONE_FIXED), "result above 1.0")

  // Two sweep ends never follow each other directly.
  `JSW_ASSERT_NEXT(a_last_gap, out_valid_o && last_of_sweep_o && !out_stall_i, !(out_valid_o && last_of_sweep_o), "sweep end flagged twice in a row")

endmodule

bind jacobi_stencil_3d_sweep_core jsw_checker u_jsw_checker (.*);
